>>> rtl/crs_pkg.sv
`timescale 1ns / 1ps
package crs_pkg;

  // Default sizes of the data and parity slice sets
  localparam int MAX_DATA_DEF   = 32;
  localparam int MAX_PARITY_DEF = 16;

  // Field widths
  localparam int BYTE_W  = 8;
  localparam int SLICE_W = 5;
  localparam int PIDX_W  = 4;
  localparam int K_W     = 6;
  localparam int M_W     = 5;
  localparam int CFG_W   = 6;
  localparam int EFF_W   = 8;

  // Register indexes
  localparam logic CFG_DATA_COUNT   = 1'b0;
  localparam logic CFG_PARITY_COUNT = 1'b1;

  // Field polynomial x^8 + x^4 + x^3 + x^2 + 1
  localparam logic [8:0] GF_POLY = 9'h11D;

  // Carry-less multiply with reduction, one bit of b per step
  function automatic logic [7:0] gf_mul(logic [7:0] a, logic [7:0] b);
    logic [8:0] x;
    logic [7:0] acc;
    x   = {1'b0, a};
    acc = '0;
    for (int n = 0; n < 8; n++) begin
      if (b[n]) acc = acc ^ x[7:0];
      x = {x[7:0], 1'b0};
      if (x[8]) x = x ^ GF_POLY;
    end
    return acc;
  endfunction

  // Inverse table, built at elaboration; zero maps to zero
  function automatic logic [255:0][7:0] gf_inv_table();
    logic [255:0][7:0] t;
    t = '0;
    for (int a = 1; a < 256; a++) begin
      for (int b = 1; b < 256; b++) begin
        if (gf_mul(8'(a), 8'(b)) == 8'd1) t[a] = 8'(b);
      end
    end
    return t;
  endfunction

  localparam logic [255:0][7:0] GF_INV = gf_inv_table();

endpackage

>>> rtl/cauchy_rs_parity_encoder.sv
`timescale 1ns / 1ps
// Channel  Dir  Signals                         Contents
// in_      in   tvalid tready tdata tuser       tdata: data_byte; tuser: slice_index
// out_     out  tvalid tready tdata tuser tlast tdata: parity_byte; tuser: parity_index;
//                                               tlast: last_of_column
// cfg_     in   we index wdata                  0: data_count, 1: parity_count
//
// One data byte is taken per cycle unless a column's end item is held: it is
// registered, then folded into the first parity_count accumulators, and the last
// slice of a column copies the finished parities into an output bank that shifts
// out one byte per cycle while out_tready is high. A column's end item waits in
// the input register while the previous column is still draining.
// Reset (synchronous, active low) clears the input valid flag, the accumulators,
// the bank count and index, and sets both counts to 1.
module cauchy_rs_parity_encoder #(
  parameter int MAX_DATA   = crs_pkg::MAX_DATA_DEF,
  parameter int MAX_PARITY = crs_pkg::MAX_PARITY_DEF
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        in_tvalid,
  output logic                        in_tready,
  input  logic [crs_pkg::BYTE_W-1:0]  in_tdata,   // [7:0] data_byte
  input  logic [crs_pkg::SLICE_W-1:0] in_tuser,   // [4:0] slice_index
  output logic                        out_tvalid,
  input  logic                        out_tready,
  output logic [crs_pkg::BYTE_W-1:0]  out_tdata,  // [7:0] parity_byte
  output logic [crs_pkg::PIDX_W-1:0]  out_tuser,  // [3:0] parity_index
  output logic                        out_tlast,
  input  logic                        cfg_we,
  input  logic                        cfg_index,
  input  logic [crs_pkg::CFG_W-1:0]   cfg_wdata
);
  import crs_pkg::*;

  localparam int CW = $clog2(MAX_PARITY + 1);

  logic [K_W-1:0]   data_count_r;
  logic [M_W-1:0]   parity_count_r;
  logic [EFF_W-1:0] k_eff;
  logic [EFF_W-1:0] m_eff;
  logic [EFF_W-1:0] dc_ext;
  logic [EFF_W-1:0] pc_ext;
  logic             drain_free;
  logic             load;
  logic [CW-1:0]    load_cnt;
  logic [7:0]       load_bytes [MAX_PARITY];

  // Configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      data_count_r   <= K_W'(1);
      parity_count_r <= M_W'(1);
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_DATA_COUNT:   data_count_r   <= cfg_wdata[K_W-1:0];
        CFG_PARITY_COUNT: parity_count_r <= cfg_wdata[M_W-1:0];
        default: ;
      endcase
    end
  end

  // Clamp counts into 1..MAX
  assign dc_ext = EFF_W'(data_count_r);
  assign pc_ext = EFF_W'(parity_count_r);
  assign k_eff  = (dc_ext == '0) ? EFF_W'(1) :
                  (dc_ext > EFF_W'(MAX_DATA)) ? EFF_W'(MAX_DATA) : dc_ext;
  assign m_eff  = (pc_ext == '0) ? EFF_W'(1) :
                  (pc_ext > EFF_W'(MAX_PARITY)) ? EFF_W'(MAX_PARITY) : pc_ext;

  crs_absorb #(
    .MAX_PARITY (MAX_PARITY),
    .CW         (CW)
  ) u_absorb (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_byte    (in_tdata),
    .in_slice   (in_tuser),
    .k_eff      (k_eff),
    .m_eff      (m_eff),
    .drain_free (drain_free),
    .load       (load),
    .load_cnt   (load_cnt),
    .load_bytes (load_bytes)
  );

  crs_drain #(
    .MAX_PARITY (MAX_PARITY),
    .CW         (CW)
  ) u_drain (
    .clk        (clk),
    .rst_n      (rst_n),
    .load       (load),
    .load_cnt   (load_cnt),
    .load_bytes (load_bytes),
    .drain_free (drain_free),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_byte   (out_tdata),
    .out_index  (out_tuser),
    .out_last   (out_tlast)
  );

endmodule

>>> rtl/crs_absorb.sv
`timescale 1ns / 1ps
module crs_absorb #(
  parameter int MAX_PARITY = crs_pkg::MAX_PARITY_DEF,
  parameter int CW         = $clog2(MAX_PARITY + 1)
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        in_tvalid,
  output logic                        in_tready,
  input  logic [crs_pkg::BYTE_W-1:0]  in_byte,
  input  logic [crs_pkg::SLICE_W-1:0] in_slice,
  input  logic [crs_pkg::EFF_W-1:0]   k_eff,
  input  logic [crs_pkg::EFF_W-1:0]   m_eff,
  input  logic                        drain_free,
  output logic                        load,
  output logic [CW-1:0]               load_cnt,
  output logic [7:0]                  load_bytes [MAX_PARITY]
);
  import crs_pkg::*;

  logic               item_vld_r;
  logic [BYTE_W-1:0]  byte_r;
  logic [SLICE_W-1:0] slice_r;
  logic [7:0]         acc_r   [MAX_PARITY];
  logic [7:0]         acc_nxt [MAX_PARITY];
  logic [EFF_W-1:0]   slice_ext;
  logic [EFF_W-1:0]   base_sum;
  logic               in_range;
  logic               term;
  logic               advance;
  logic               absorb;

  assign slice_ext = EFF_W'(slice_r);
  assign base_sum  = m_eff + slice_ext;
  assign in_range  = slice_ext < k_eff;
  assign term      = in_range && (slice_ext == k_eff - EFF_W'(1));

  // Hold a finishing item while the output bank is still draining
  assign advance   = !(term && !drain_free);
  assign in_tready = !item_vld_r || advance;
  assign absorb    = item_vld_r && advance && in_range;
  assign load      = absorb && term;
  assign load_cnt  = CW'(m_eff);

  // Multiply the byte by each row coefficient and fold it in
  always_comb begin
    logic [7:0] diff;
    logic [7:0] base;
    for (int i = 0; i < MAX_PARITY; i++) begin
      diff = 8'(i) ^ base_sum;
      base = (slice_r == '0) ? 8'd0 : acc_r[i];
      if (EFF_W'(i) < m_eff) begin
        acc_nxt[i] = base ^ gf_mul(byte_r, GF_INV[diff]);
      end else begin
        acc_nxt[i] = base;
      end
    end
  end

  assign load_bytes = acc_nxt;

  // Input register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      item_vld_r <= 1'b0;
    end else if (in_tready) begin
      item_vld_r <= in_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_tready && in_tvalid) begin
      byte_r  <= in_byte;
      slice_r <= in_slice;
    end
  end

  // Accumulators; clear at the end of each column
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < MAX_PARITY; i++) acc_r[i] <= '0;
    end else if (absorb) begin
      for (int i = 0; i < MAX_PARITY; i++) acc_r[i] <= term ? 8'd0 : acc_nxt[i];
    end
  end

endmodule

>>> rtl/crs_drain.sv
`timescale 1ns / 1ps
module crs_drain #(
  parameter int MAX_PARITY = crs_pkg::MAX_PARITY_DEF,
  parameter int CW         = $clog2(MAX_PARITY + 1)
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       load,
  input  logic [CW-1:0]              load_cnt,
  input  logic [7:0]                 load_bytes [MAX_PARITY],
  output logic                       drain_free,
  output logic                       out_tvalid,
  input  logic                       out_tready,
  output logic [crs_pkg::BYTE_W-1:0] out_byte,
  output logic [crs_pkg::PIDX_W-1:0] out_index,
  output logic                       out_last
);
  import crs_pkg::*;

  logic [7:0]        bank_r   [MAX_PARITY];
  logic [7:0]        bank_nxt [MAX_PARITY];
  logic [CW-1:0]     cnt_r;
  logic [PIDX_W-1:0] idx_r;
  logic              pop;

  assign out_tvalid = cnt_r != '0;
  assign pop        = out_tvalid && out_tready;
  assign drain_free = (cnt_r == '0) || ((cnt_r == CW'(1)) && out_tready);
  assign out_byte   = bank_r[0];
  assign out_index  = idx_r;
  assign out_last   = cnt_r == CW'(1);

  // Shift the bank down by one on each taken request
  always_comb begin
    bank_nxt = bank_r;
    for (int i = 0; i < MAX_PARITY - 1; i++) bank_nxt[i] = bank_r[i + 1];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= '0;
      idx_r <= '0;
    end else if (load) begin
      cnt_r <= load_cnt;
      idx_r <= '0;
    end else if (pop) begin
      cnt_r <= cnt_r - CW'(1);
      idx_r <= idx_r + PIDX_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      bank_r <= load_bytes;
    end else if (pop) begin
      bank_r <= bank_nxt;
    end
  end

endmodule
